@@ src/pso_pkg.sv @@
package pso_pkg;

   localparam int VAL_W   = 32;
   localparam int RAND_W  = 16;
   localparam int GAIN_W  = 16;
   localparam int LIM_W   = 31;
   localparam int SIDE_W  = 2;
   localparam int FRAC_W  = 12;
   localparam int CSR_IDX_W = 8;

   localparam int REQ_DATA_W = 256;
   localparam int RSP_DATA_W = 64;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd8192;

   localparam logic [CSR_IDX_W-1:0] REG_GAIN_PERSONAL = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_GLOBAL   = 8'd1;

   typedef enum logic [SIDE_W-1:0] {
      SIDE_NONE  = 2'd0,
      SIDE_UPPER = 2'd1,
      SIDE_LOWER = 2'd2
   } side_type;

endpackage

@@ src/pso_particle_update.sv @@
// Channel   Ports          Direction  Payload
// request   req_t*         in         position, velocity, bests, draws, bounds, limit
// response  rsp_t*         out        new position, new velocity, bounce side
// csr       csr_*          in         register index and write data
//
// One request enters per cycle unless a stalled response holds the pipeline; each response
// passes through six register stages: coefficients, pull products, velocity sum,
// saturate and clamp, position sum, reflection.
// Reset is synchronous, clears the stage valid bits and loads the gain registers with GAIN_RESET.
// A stalled response holds the whole pipeline; nothing is dropped or repeated.
module pso_particle_update (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // position, velocity, personal_best, global_best, rand_personal, rand_global,
   // low_bound, high_bound, speed_limit, one zero pad bit
   input  logic [pso_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // new_position, new_velocity
   output logic [pso_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // bounce_side
   output logic [pso_pkg::SIDE_W-1:0]         rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pso_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pso_pkg::GAIN_W-1:0]         csr_data
);

   logic adv;
   logic [pso_pkg::GAIN_W-1:0] gain_p_ff, gain_g_ff;
   logic [5:0] vld_ff;

   logic signed [31:0] in_x, in_v, in_p, in_g, in_lo, in_hi;
   logic [15:0] in_r1, in_r2;
   logic [30:0] in_lim;

   // Stage 1
   logic [31:0] mul1_full, mul2_full;
   logic [15:0] c1_in, c2_in, c1_ff, c2_ff;
   logic signed [32:0] d1_in, d2_in, d1_ff, d2_ff;
   logic signed [31:0] x1_ff, v1_ff, lo1_ff, hi1_ff;
   logic [30:0] lim1_ff;

   // Stage 2
   logic signed [49:0] prod1, prod2;
   logic signed [37:0] t1_ff, t2_ff;
   logic signed [31:0] x2_ff, v2_ff, lo2_ff, hi2_ff;
   logic [30:0] lim2_ff;

   // Stage 3
   logic signed [39:0] sum_in, sum_ff;
   logic signed [31:0] x3_ff, lo3_ff, hi3_ff;
   logic [30:0] lim3_ff;

   // Stage 4
   logic signed [31:0] sat_v;
   logic signed [32:0] sat_vx, lim_s, neg_lim;
   logic signed [31:0] nv_in, nv4_ff, x4_ff, lo4_ff, hi4_ff;

   // Stage 5
   logic signed [32:0] nx_in, nx5_ff;
   logic signed [33:0] ovh_in, ovl_in, ovh_ff, ovl_ff;
   logic signed [31:0] nv5_ff, lo5_ff, hi5_ff;

   // Stage 6
   logic signed [34:0] pos_w;
   logic signed [32:0] neg_v;
   logic signed [31:0] pos_in, vel_in, pos_ff, vel_ff;
   pso_pkg::side_type side_in, side_ff;

   assign adv        = !vld_ff[5] || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = vld_ff[5];
   assign rsp_tdata  = {vel_ff, pos_ff};
   assign rsp_tuser  = side_ff;

   assign in_x   = $signed(req_tdata[31:0]);
   assign in_v   = $signed(req_tdata[63:32]);
   assign in_p   = $signed(req_tdata[95:64]);
   assign in_g   = $signed(req_tdata[127:96]);
   assign in_r1  = req_tdata[143:128];
   assign in_r2  = req_tdata[159:144];
   assign in_lo  = $signed(req_tdata[191:160]);
   assign in_hi  = $signed(req_tdata[223:192]);
   assign in_lim = req_tdata[254:224];

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= pso_pkg::GAIN_RESET;
         gain_g_ff <= pso_pkg::GAIN_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            pso_pkg::REG_GAIN_PERSONAL: gain_p_ff <= csr_data;
            pso_pkg::REG_GAIN_GLOBAL:   gain_g_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[4:0], req_tvalid};
      end
   end

   always_comb begin
      mul1_full = 32'(gain_p_ff) * 32'(in_r1);
      mul2_full = 32'(gain_g_ff) * 32'(in_r2);
      c1_in     = mul1_full[31:16];
      c2_in     = mul2_full[31:16];
      d1_in     = 33'(in_p) - 33'(in_x);
      d2_in     = 33'(in_g) - 33'(in_x);
   end

   always_comb begin
      prod1 = 50'(d1_ff) * 50'($signed({1'b0, c1_ff}));
      prod2 = 50'(d2_ff) * 50'($signed({1'b0, c2_ff}));
   end

   assign sum_in = 40'(v2_ff) + 40'(t1_ff) + 40'(t2_ff);

   always_comb begin
      if (sum_ff[39:31] != {9{sum_ff[39]}}) begin
         sat_v = sum_ff[39] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         sat_v = sum_ff[31:0];
      end
      sat_vx  = 33'(sat_v);
      lim_s   = $signed({2'b00, lim3_ff});
      neg_lim = -lim_s;
      if (sat_vx < neg_lim) begin
         nv_in = neg_lim[31:0];
      end else if (sat_vx > lim_s) begin
         nv_in = lim_s[31:0];
      end else begin
         nv_in = sat_v;
      end
   end

   always_comb begin
      nx_in  = 33'(x4_ff) + 33'(nv4_ff);
      ovh_in = 34'(nx_in) - 34'(hi4_ff);
      ovl_in = 34'(lo4_ff) - 34'(nx_in);
   end

   always_comb begin
      neg_v = -33'(nv5_ff);
      if (!ovh_ff[33] && ovh_ff != '0) begin
         pos_w   = 35'(hi5_ff) - 35'(ovh_ff >>> 1);
         vel_in  = 32'(neg_v >>> 1);
         side_in = pso_pkg::SIDE_UPPER;
      end else if (!ovl_ff[33] && ovl_ff != '0) begin
         pos_w   = 35'(lo5_ff) + 35'(ovl_ff >>> 1);
         vel_in  = 32'(neg_v >>> 1);
         side_in = pso_pkg::SIDE_LOWER;
      end else begin
         pos_w   = 35'(nx5_ff);
         vel_in  = nv5_ff;
         side_in = pso_pkg::SIDE_NONE;
      end
      if (pos_w[34:31] != {4{pos_w[34]}}) begin
         pos_in = pos_w[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         pos_in = pos_w[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c1_ff   <= c1_in;
         c2_ff   <= c2_in;
         d1_ff   <= d1_in;
         d2_ff   <= d2_in;
         x1_ff   <= in_x;
         v1_ff   <= in_v;
         lo1_ff  <= in_lo;
         hi1_ff  <= in_hi;
         lim1_ff <= in_lim;

         t1_ff   <= prod1[49:12];
         t2_ff   <= prod2[49:12];
         x2_ff   <= x1_ff;
         v2_ff   <= v1_ff;
         lo2_ff  <= lo1_ff;
         hi2_ff  <= hi1_ff;
         lim2_ff <= lim1_ff;

         sum_ff  <= sum_in;
         x3_ff   <= x2_ff;
         lo3_ff  <= lo2_ff;
         hi3_ff  <= hi2_ff;
         lim3_ff <= lim2_ff;

         nv4_ff  <= nv_in;
         x4_ff   <= x3_ff;
         lo4_ff  <= lo3_ff;
         hi4_ff  <= hi3_ff;

         nx5_ff  <= nx_in;
         ovh_ff  <= ovh_in;
         ovl_ff  <= ovl_in;
         nv5_ff  <= nv4_ff;
         lo5_ff  <= lo4_ff;
         hi5_ff  <= hi4_ff;

         pos_ff  <= pos_in;
         vel_ff  <= vel_in;
         side_ff <= side_in;
      end
   end

endmodule

@@ src/pso_checker.sv @@
module pso_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [pso_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [pso_pkg::SIDE_W-1:0]     rsp_tuser,
   input logic                           csr_valid,
   input logic                           csr_ready
);

   // A pending response stays offered until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // The pipeline is empty in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response offered right after reset");

   // A reflected velocity is half of a clamped one, so its top two bits agree.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == pso_pkg::SIDE_UPPER || rsp_tuser == pso_pkg::SIDE_LOWER)
      |-> rsp_tdata[63] == rsp_tdata[62])
      else $error("reflected velocity out of range");

   // The bounce side never takes the unused code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == pso_pkg::SIDE_NONE || rsp_tuser == pso_pkg::SIDE_UPPER
                      || rsp_tuser == pso_pkg::SIDE_LOWER))
      else $error("bad bounce side");

   // Register writes are never held off.
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

endmodule

bind pso_particle_update pso_checker u_pso_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);

@@ test/pso_update_checker.sv @@
module pso_update_checker
   import pso_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [SIDE_W-1:0]     rsp_tuser,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [GAIN_W-1:0]     csr_data,
   output int                    mismatches,
   output int                    in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -64'sd2147483648;

   typedef struct packed {
      logic [VAL_W-1:0] position;
      logic [VAL_W-1:0] velocity;
      side_type         side;
   } particle_update_type;

   particle_update_type expected_updates[$];
   logic [GAIN_W-1:0] gain_p = GAIN_RESET;
   logic [GAIN_W-1:0] gain_g = GAIN_RESET;

   initial begin
      mismatches = 0;
      in_flight  = 0;
   end

   function automatic longint sat_q16(input longint a);
      if (a > Q_MAX) return Q_MAX;
      if (a < Q_MIN) return Q_MIN;
      return a;
   endfunction

   function automatic particle_update_type advance_particle(
                                                input logic [REQ_DATA_W-1:0] d,
                                                input logic [GAIN_W-1:0] g1,
                                                input logic [GAIN_W-1:0] g2);
      longint x, v, pb, gb, lo, hi, lim, c1, c2, nv, nx, pos;
      logic [31:0] prod1, prod2;
      particle_update_type r;
      x     = $signed(d[31:0]);
      v     = $signed(d[63:32]);
      pb    = $signed(d[95:64]);
      gb    = $signed(d[127:96]);
      lo    = $signed(d[191:160]);
      hi    = $signed(d[223:192]);
      lim   = longint'(d[254:224]);
      prod1 = g1 * d[143:128];
      prod2 = g2 * d[159:144];
      c1    = longint'(prod1[31:16]);
      c2    = longint'(prod2[31:16]);
      nv    = v + (((pb - x) * c1) >>> FRAC_W) + (((gb - x) * c2) >>> FRAC_W);
      nv    = sat_q16(nv);
      if (nv < -lim) nv = -lim;
      else if (nv > lim) nv = lim;
      nx = x + nv;
      if (nx > hi) begin
         pos    = hi - ((nx - hi) >>> 1);
         nv     = (-nv) >>> 1;
         r.side = SIDE_UPPER;
      end else if (nx < lo) begin
         pos    = lo + ((lo - nx) >>> 1);
         nv     = (-nv) >>> 1;
         r.side = SIDE_LOWER;
      end else begin
         pos    = nx;
         r.side = SIDE_NONE;
      end
      pos        = sat_q16(pos);
      r.position = pos[31:0];
      r.velocity = nv[31:0];
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch in %s: got %h, expected %h", field, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      particle_update_type want;
      if (reset) begin
         gain_p = GAIN_RESET;
         gain_g = GAIN_RESET;
         expected_updates.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_GAIN_PERSONAL) gain_p = csr_data;
            else if (csr_index == REG_GAIN_GLOBAL) gain_g = csr_data;
         end
         if (req_tvalid && req_tready)
            expected_updates.insert(expected_updates.size(),
                                    advance_particle(req_tdata, gain_p, gain_g));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_updates.size() == 0) begin
               report_mismatch("unexpected response", rsp_tdata[31:0], '0);
            end else begin
               want = expected_updates.pop_front();
               if (rsp_tdata[31:0] !== want.position)
                  report_mismatch("new_position", rsp_tdata[31:0], want.position);
               if (rsp_tdata[63:32] !== want.velocity)
                  report_mismatch("new_velocity", rsp_tdata[63:32], want.velocity);
               if (rsp_tuser !== want.side)
                  report_mismatch("bounce_side", 32'(rsp_tuser), 32'(want.side));
            end
         end
      end
      in_flight <= expected_updates.size();
   end

endmodule

@@ test/tb_pso_particle_update.sv @@
module tb_pso_particle_update
   import pso_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          LIMIT       = 400000;
   localparam int          HOLD_CYCLES = 400;
   localparam logic [31:0] ONE         = 32'h0001_0000;
   localparam logic [31:0] Q_MAX       = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN       = 32'h8000_0000;
   localparam logic [30:0] LIM_MAX     = 31'h7FFF_FFFF;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_LOW  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_HIGH = 8'hFF;

   typedef enum {RX_OPEN, RX_COIN, RX_LIGHT, RX_HEAVY} rx_mode_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [SIDE_W-1:0]     rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [GAIN_W-1:0]     csr_data   = '0;

   int          mismatches;
   int          in_flight;
   int          burst_left   = 0;
   int          random_phase = -1;
   int          cycle_count  = 0;
   logic        long_hold    = 1'b0;
   rx_mode_type rx_mode      = RX_OPEN;
   int          rx_count     = 0;

   pso_particle_update uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   pso_update_checker u_update_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .in_flight  (in_flight)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (rx_count == 0) begin
         rx_mode  <= rx_mode_type'($urandom_range(0, 3));
         rx_count <= $urandom_range(8, 64);
      end else begin
         rx_count <= rx_count - 1;
      end
      if (long_hold) begin
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_OPEN:  rsp_tready <= 1'b1;
            RX_COIN:  rsp_tready <= 1'($urandom_range(0, 1));
            RX_LIGHT: rsp_tready <= ($urandom_range(0, 7) != 0);
            default:  rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // The receiver stops for a long stretch so that the pipeline fills and
   // the request side backs up.
   initial begin
      wait (random_phase == 3);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL pso_particle_update");
      $finish;
   end

   function automatic logic [31:0] clip_q16(input longint a);
      if (a > longint'($signed(Q_MAX))) return Q_MAX;
      if (a < longint'($signed(Q_MIN))) return Q_MIN;
      return a[31:0];
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pack_request(
      input logic [31:0] x, input logic [31:0] v, input logic [31:0] pb,
      input logic [31:0] gb, input logic [15:0] r1, input logic [15:0] r2,
      input logic [31:0] lo, input logic [31:0] hi, input logic [30:0] lim);
      return {1'b0, lim, hi, lo, r2, r1, gb, pb, v, x};
   endfunction

   function automatic logic [REQ_DATA_W-1:0] random_request();
      int          sh;
      longint      center, half, lo, hi, span;
      logic [31:0] x, v, pb, gb;
      logic [15:0] r1, r2;
      logic [30:0] lim;
      if ($urandom_range(0, 9) < 3)
         return pack_request($urandom, $urandom, $urandom, $urandom, 16'($urandom),
                             16'($urandom), $urandom, $urandom, 31'($urandom));
      sh     = $urandom_range(4, 14);
      center = longint'($signed($urandom)) >>> sh;
      half   = longint'($urandom_range(0, 32'h0400_0000) >> $urandom_range(0, 10));
      lo     = $signed(clip_q16(center - half));
      hi     = $signed(clip_q16(center + half));
      span   = hi - lo;
      x      = clip_q16(lo + longint'($urandom_range(0, 32'(span))));
      pb     = clip_q16(lo - span + longint'($urandom_range(0, 32'(3 * span))));
      gb     = clip_q16(lo - span + longint'($urandom_range(0, 32'(3 * span))));
      v      = clip_q16(longint'($urandom_range(0, 32'(2 * span))) - span);
      r1     = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom);
      r2     = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom);
      case ($urandom_range(0, 5))
         0:       lim = '0;
         1:       lim = LIM_MAX;
         default: lim = 31'($urandom_range(0, 32'(span)));
      endcase
      return pack_request(x, v, pb, gb, r1, r2, lo[31:0], hi[31:0], lim);
   endfunction

   task automatic send_request(input logic [REQ_DATA_W-1:0] data);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   task automatic send_fields(
      input logic [31:0] x, input logic [31:0] v, input logic [31:0] pb,
      input logic [31:0] gb, input logic [15:0] r1, input logic [15:0] r2,
      input logic [31:0] lo, input logic [31:0] hi, input logic [30:0] lim);
      send_request(pack_request(x, v, pb, gb, r1, r2, lo, hi, lim));
   endtask

   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (in_flight != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] index,
                            input logic [GAIN_W-1:0] value, input bit last);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (last) csr_valid <= 1'b0;
   endtask

   task automatic set_gains(input logic [GAIN_W-1:0] gp, input logic [GAIN_W-1:0] gg);
      csr_write(REG_GAIN_PERSONAL, gp, 1'b0);
      csr_write(REG_GAIN_GLOBAL, gg, 1'b1);
   endtask

   initial begin
      logic [GAIN_W-1:0] gp, gg;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset gains: bounds handling and the corner cases of the update.
      send_fields('0, '0, '0, '0, '0, '0, '0, '0, '0);
      send_fields(ONE, ONE / 2, 2 * ONE, 3 * ONE, 16'h8000, 16'h4000,
                  -10 * ONE, 10 * ONE, 31'(4 * ONE));
      send_fields(9 * ONE, 3 * ONE, 9 * ONE, 9 * ONE, '0, '0, -10 * ONE, 10 * ONE,
                  31'(4 * ONE));
      send_fields(-9 * ONE, -3 * ONE, -9 * ONE, -9 * ONE, '0, '0, -10 * ONE, 10 * ONE,
                  31'(4 * ONE));
      send_fields('0, '0, ONE, -ONE, 16'h1234, 16'h4321, 5 * ONE, -5 * ONE,
                  31'(4 * ONE));
      send_fields(ONE / 2, 3 * ONE, ONE / 2, ONE / 2, '0, '0, '0, ONE, 31'(4 * ONE));
      send_fields('0, ONE, Q_MAX, Q_MIN, '0, '0, -10 * ONE, 10 * ONE, 31'(4 * ONE));
      send_fields('0, 7 * ONE, 5 * ONE, -5 * ONE, 16'hFFFF, 16'hFFFF, -10 * ONE,
                  10 * ONE, '0);
      send_fields(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 16'hFFFF, 16'hFFFF, Q_MIN, Q_MAX, LIM_MAX);
      send_fields(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 16'hFFFF, 16'hFFFF, Q_MIN, Q_MAX, LIM_MAX);
      send_fields(Q_MIN, Q_MAX, Q_MAX, Q_MAX, 16'hFFFF, 16'hFFFF, Q_MIN, Q_MAX, LIM_MAX);
      send_fields(Q_MAX, Q_MIN, Q_MIN, Q_MIN, 16'hFFFF, 16'hFFFF, Q_MIN, Q_MAX, LIM_MAX);
      send_fields(Q_MAX, Q_MAX, '0, '0, '0, '0, Q_MIN, Q_MIN, LIM_MAX);
      send_fields(Q_MIN, Q_MIN, '0, '0, '0, '0, Q_MAX, Q_MAX, LIM_MAX);
      send_fields(-3, '0, '0, 3, 16'h0001, 16'hFFFF, Q_MIN, Q_MAX, LIM_MAX);
      wait_for_responses();

      // Largest gains; writes to indexes outside the register list are ignored.
      csr_write(REG_UNUSED_LOW, 16'hFFFF, 1'b0);
      csr_write(REG_UNUSED_HIGH, 16'h0000, 1'b0);
      set_gains(16'hFFFF, 16'hFFFF);
      send_fields(Q_MIN, Q_MAX, Q_MAX, Q_MAX, 16'hFFFF, 16'hFFFF, Q_MIN, Q_MAX, LIM_MAX);
      send_fields(Q_MAX, Q_MIN, Q_MIN, Q_MIN, 16'hFFFF, 16'hFFFF, Q_MIN, Q_MAX, LIM_MAX);
      send_fields(ONE, '0, 4 * ONE, -4 * ONE, 16'h8000, 16'h8000, -10 * ONE, 10 * ONE,
                  31'(8 * ONE));
      send_fields(-2 * ONE, ONE, 9 * ONE, 9 * ONE, 16'hFFFF, 16'h0000, -10 * ONE,
                  10 * ONE, LIM_MAX);
      wait_for_responses();

      set_gains('0, '0);
      send_fields(ONE, ONE / 2, Q_MAX, Q_MIN, 16'hFFFF, 16'hFFFF, -10 * ONE, 10 * ONE,
                  31'(4 * ONE));
      send_fields(-ONE, -(ONE / 2), Q_MIN, Q_MAX, 16'hFFFF, 16'hFFFF, -10 * ONE, 10 * ONE,
                  31'(4 * ONE));
      wait_for_responses();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin gp = 16'hFFFF; gg = 16'h0000; end
            1: begin gp = 16'h0000; gg = 16'hFFFF; end
            4: begin gp = GAIN_RESET; gg = GAIN_RESET; end
            default: begin gp = 16'($urandom); gg = 16'($urandom); end
         endcase
         set_gains(gp, gg);
         random_phase = ph;
         repeat (120) send_request(random_request());
         wait_for_responses();
      end

      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS pso_particle_update");
      end else begin
         $display("FAIL pso_particle_update");
      end
      $finish;
   end

endmodule
